>>> rtl/core/lcc_pkg.sv
// Shared types, constants and the microcode program of the level crossing counter.
`timescale 1ns / 1ps
`default_nettype none

package lcc_pkg;

  localparam int UPC_W     = 6;
  localparam int UCODE_LEN = 34;

  // Micro-operations of the sequencer.
  typedef enum logic [3:0] {
    U_IDLE,   // wait for an item; dispatch is done by the accept logic
    U_RDL,    // read height left of the position
    U_RDC,    // read height at the position, capture left height
    U_RDR,    // read height right of the position, capture center height
    U_LATR,   // capture right height
    U_SETLO,  // start a step range at its low end, skip when the step is not rising
    U_SETHI,  // restart at the high end with the opposite delta
    U_ARD,    // read tree entry, leave the walk when the index passes the top
    U_AWR,    // write tree entry plus delta, advance index by its lowest set bit
    U_WRH,    // write the new height
    U_END,    // back to idle
    U_QRD,    // read tree entry for a prefix sum, leave when the index is zero
    U_QACC,   // accumulate, drop the lowest set bit of the index
    U_OUT     // hand the count to the output register
  } uop_t;

  typedef struct packed {
    uop_t             op;
    logic             pair_right;  // step between center and right neighbor
    logic             neg;         // remove the step instead of adding it
    logic [UPC_W-1:0] target;      // jump address
  } ucw_t;

  localparam logic [UPC_W-1:0] UPC_IDLE  = 6'd0;
  localparam logic [UPC_W-1:0] UPC_SET   = 6'd1;
  localparam logic [UPC_W-1:0] UPC_QUERY = 6'd31;
  localparam logic [UPC_W-1:0] UPC_OUT   = 6'd33;

  // Each step update is six words: low end walk, high end walk.
  localparam ucw_t UCODE [UCODE_LEN] = '{
    '{U_IDLE,  1'b0, 1'b0, 6'd0},   // 0
    '{U_RDL,   1'b0, 1'b0, 6'd0},   // 1
    '{U_RDC,   1'b0, 1'b0, 6'd0},   // 2
    '{U_RDR,   1'b0, 1'b0, 6'd0},   // 3
    '{U_LATR,  1'b0, 1'b0, 6'd0},   // 4
    // Remove the left step.
    '{U_SETLO, 1'b0, 1'b1, 6'd11},  // 5
    '{U_ARD,   1'b0, 1'b1, 6'd8},   // 6
    '{U_AWR,   1'b0, 1'b1, 6'd6},   // 7
    '{U_SETHI, 1'b0, 1'b1, 6'd0},   // 8
    '{U_ARD,   1'b0, 1'b1, 6'd11},  // 9
    '{U_AWR,   1'b0, 1'b1, 6'd9},   // 10
    // Remove the right step.
    '{U_SETLO, 1'b1, 1'b1, 6'd17},  // 11
    '{U_ARD,   1'b1, 1'b1, 6'd14},  // 12
    '{U_AWR,   1'b1, 1'b1, 6'd12},  // 13
    '{U_SETHI, 1'b1, 1'b1, 6'd0},   // 14
    '{U_ARD,   1'b1, 1'b1, 6'd17},  // 15
    '{U_AWR,   1'b1, 1'b1, 6'd15},  // 16
    '{U_WRH,   1'b0, 1'b0, 6'd0},   // 17
    // Add the left step back.
    '{U_SETLO, 1'b0, 1'b0, 6'd24},  // 18
    '{U_ARD,   1'b0, 1'b0, 6'd21},  // 19
    '{U_AWR,   1'b0, 1'b0, 6'd19},  // 20
    '{U_SETHI, 1'b0, 1'b0, 6'd0},   // 21
    '{U_ARD,   1'b0, 1'b0, 6'd24},  // 22
    '{U_AWR,   1'b0, 1'b0, 6'd22},  // 23
    // Add the right step back.
    '{U_SETLO, 1'b1, 1'b0, 6'd30},  // 24
    '{U_ARD,   1'b1, 1'b0, 6'd27},  // 25
    '{U_AWR,   1'b1, 1'b0, 6'd25},  // 26
    '{U_SETHI, 1'b1, 1'b0, 6'd0},   // 27
    '{U_ARD,   1'b1, 1'b0, 6'd30},  // 28
    '{U_AWR,   1'b1, 1'b0, 6'd28},  // 29
    '{U_END,   1'b0, 1'b0, 6'd0},   // 30
    // Query prefix sum.
    '{U_QRD,   1'b0, 1'b0, 6'd33},  // 31
    '{U_QACC,  1'b0, 1'b0, 6'd31},  // 32
    '{U_OUT,   1'b0, 1'b0, 6'd0}    // 33
  };

endpackage

`default_nettype wire

>>> rtl/core/lcc_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lcc_ram #(
  parameter int DEPTH = 1026,
  parameter int WIDTH = 11,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/level_crossing_counter.sv
// Top level of the level crossing counter: microcoded sequencer, datapath and stores.
`timescale 1ns / 1ps
`default_nettype none

// One item is in work at a time. A query reads one tree entry per set bit of the level, or
// none for level zero or a level above the top, and then raises out_valid. A set walks the
// tree by read-modify-write of each entry, gives no result, and the next item is taken after it.
// After reset a clearing pass over max(POSITIONS + 2, LEVELS + 1) entries zeroes both stores,
// and in_stall stays high until it is done.
module level_crossing_counter #(
  parameter int POSITIONS = 1024,
  parameter int LEVELS    = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [10:0] in_position,
  input  logic [10:0] in_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_crossing_count
);

  import lcc_pkg::*;

  // Height values, height store address, tree store address and tree index widths.
  localparam int HW  = $clog2(LEVELS + 1);
  localparam int HAW = $clog2(POSITIONS + 2);
  localparam int TAW = $clog2(LEVELS + 1);
  localparam int XW  = TAW + 1;
  // Tree entries hold signed differences of crossing counts.
  localparam int CW  = $clog2(POSITIONS + 2) + 1;
  localparam int CLR_LEN = (POSITIONS + 2 > LEVELS + 1) ? POSITIONS + 2 : LEVELS + 1;
  localparam int CLW = $clog2(CLR_LEN);

  // Sequencer and control.
  logic [UPC_W-1:0] pc_r, pc_nxt;
  logic             clr_active_r, clr_active_nxt;
  logic [CLW-1:0]   clr_idx_r, clr_idx_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Datapath registers.
  logic [HAW-1:0]       pos_r, pos_nxt;
  logic [HW-1:0]        newh_r, newh_nxt;
  logic [HW-1:0]        hl_r, hl_nxt;
  logic [HW-1:0]        hc_r, hc_nxt;
  logic [HW-1:0]        hr_r, hr_nxt;
  logic [XW-1:0]        x_r, x_nxt;
  logic signed [1:0]    v_r, v_nxt;
  logic signed [CW-1:0] acc_r, acc_nxt;
  logic [10:0]          count_r, count_nxt;

  // Store ports.
  logic           h_we, h_re;
  logic [HAW-1:0] h_waddr, h_raddr;
  logic [HW-1:0]  h_wdata, h_rdata;
  logic           t_we, t_re;
  logic [TAW-1:0] t_waddr;
  logic [CW-1:0]  t_wdata, t_rdata;

  ucw_t           cw;
  logic           in_accept;
  logic [31:0]    pos32, lvl32, clamp32, x32;
  logic [HW-1:0]  lo, hi;
  logic [XW-1:0]  x_low;
  logic [31:0]    acc32;

  lcc_ram #(.DEPTH(POSITIONS + 2), .WIDTH(HW)) u_heights (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (h_re),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  lcc_ram #(.DEPTH(LEVELS + 1), .WIDTH(CW)) u_tree (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .re    (t_re),
    .raddr (x_r[TAW-1:0]),
    .rdata (t_rdata)
  );

  assign cw        = UCODE[pc_r];
  assign in_stall  = clr_active_r || (pc_r != UPC_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_crossing_count = count_r;

  assign pos32   = 32'(in_position);
  assign lvl32   = 32'(in_level);
  assign clamp32 = (lvl32 > LEVELS) ? 32'(LEVELS) : lvl32;
  assign x32     = 32'(x_r);

  // The two heights that bound the step being updated.
  assign lo    = cw.pair_right ? hc_r : hl_r;
  assign hi    = cw.pair_right ? hr_r : hc_r;
  assign x_low = x_r & (~x_r + XW'(1));
  assign acc32 = 32'(acc_r);

  always_comb begin
    pc_nxt         = pc_r + UPC_W'(1);
    clr_active_nxt = clr_active_r;
    clr_idx_nxt    = clr_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    pos_nxt        = pos_r;
    newh_nxt       = newh_r;
    hl_nxt         = hl_r;
    hc_nxt         = hc_r;
    hr_nxt         = hr_r;
    x_nxt          = x_r;
    v_nxt          = v_r;
    acc_nxt        = acc_r;
    count_nxt      = count_r;

    h_we    = 1'b0;
    h_waddr = pos_r;
    h_wdata = newh_r;
    h_re    = 1'b0;
    h_raddr = pos_r;
    t_we    = 1'b0;
    t_waddr = x_r[TAW-1:0];
    t_wdata = t_rdata + CW'(v_r);
    t_re    = 1'b0;

    if (clr_active_r) begin
      // Zero both stores, one entry of each per cycle.
      pc_nxt = UPC_IDLE;
      if (32'(clr_idx_r) < POSITIONS + 2) begin
        h_we    = 1'b1;
        h_waddr = clr_idx_r[HAW-1:0];
        h_wdata = '0;
      end
      if (32'(clr_idx_r) < LEVELS + 1) begin
        t_we    = 1'b1;
        t_waddr = clr_idx_r[TAW-1:0];
        t_wdata = '0;
      end
      if (32'(clr_idx_r) == CLR_LEN - 1) begin
        clr_active_nxt = 1'b0;
      end else begin
        clr_idx_nxt = clr_idx_r + CLW'(1);
      end
    end else begin
      case (cw.op)
        U_IDLE: begin
          pc_nxt = UPC_IDLE;
          if (in_accept) begin
            if (in_func) begin
              // A set outside the row is dropped without any work.
              pos_nxt  = pos32[HAW-1:0];
              newh_nxt = clamp32[HW-1:0];
              if (pos32 >= 32'd1 && pos32 <= POSITIONS) begin
                pc_nxt = UPC_SET;
              end
            end else begin
              // Level zero and levels above the top answer zero directly.
              acc_nxt = '0;
              x_nxt   = lvl32[XW-1:0];
              if (lvl32 == 32'd0 || lvl32 > LEVELS) begin
                pc_nxt = UPC_OUT;
              end else begin
                pc_nxt = UPC_QUERY;
              end
            end
          end
        end
        U_RDL: begin
          h_re    = 1'b1;
          h_raddr = pos_r - HAW'(1);
        end
        U_RDC: begin
          h_re    = 1'b1;
          h_raddr = pos_r;
          hl_nxt  = h_rdata;
        end
        U_RDR: begin
          h_re    = 1'b1;
          h_raddr = pos_r + HAW'(1);
          hc_nxt  = h_rdata;
        end
        U_LATR: begin
          hr_nxt = h_rdata;
        end
        U_SETLO: begin
          x_nxt = XW'(lo) + XW'(1);
          v_nxt = cw.neg ? -2'sd1 : 2'sd1;
          if (!(lo < hi)) begin
            pc_nxt = cw.target;
          end
        end
        U_SETHI: begin
          x_nxt = XW'(hi) + XW'(1);
          v_nxt = -v_r;
        end
        U_ARD: begin
          if (x32 > LEVELS) begin
            pc_nxt = cw.target;
          end else begin
            t_re = 1'b1;
          end
        end
        U_AWR: begin
          t_we    = 1'b1;
          t_waddr = x_r[TAW-1:0];
          t_wdata = t_rdata + CW'(v_r);
          x_nxt   = x_r + x_low;
          pc_nxt  = cw.target;
        end
        U_WRH: begin
          h_we    = 1'b1;
          h_waddr = pos_r;
          h_wdata = newh_r;
          hc_nxt  = newh_r;
        end
        U_END: begin
          pc_nxt = cw.target;
        end
        U_QRD: begin
          if (x_r == '0) begin
            pc_nxt = cw.target;
          end else begin
            t_re = 1'b1;
          end
        end
        U_QACC: begin
          acc_nxt = acc_r + $signed(t_rdata);
          x_nxt   = x_r - x_low;
          pc_nxt  = cw.target;
        end
        U_OUT: begin
          // Wait until the output register is free or being emptied.
          if (!out_valid_r || !out_stall) begin
            out_valid_nxt = 1'b1;
            count_nxt     = acc32[10:0];
            pc_nxt        = cw.target;
          end else begin
            pc_nxt = pc_r;
          end
        end
        default: begin
          pc_nxt = UPC_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= UPC_IDLE;
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pc_r         <= pc_nxt;
      clr_active_r <= clr_active_nxt;
      clr_idx_r    <= clr_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    newh_r  <= newh_nxt;
    hl_r    <= hl_nxt;
    hc_r    <= hc_nxt;
    hr_r    <= hr_nxt;
    x_r     <= x_nxt;
    v_r     <= v_nxt;
    acc_r   <= acc_nxt;
    count_r <= count_nxt;
  end

endmodule

`default_nettype wire

>>> tb/sv/lcc_tb_pkg.sv
// Item codes and block sizes shared by the level crossing counter testbench files.
`timescale 1ns / 1ps

package lcc_tb_pkg;

  localparam logic FUNC_QUERY = 1'b0;
  localparam logic FUNC_SET   = 1'b1;

  localparam int POSITIONS = 1024;
  localparam int LEVELS    = 1024;

  typedef struct packed {
    logic [10:0] level;
    logic [10:0] count;
  } crossing_answer_t;

endpackage

>>> tb/sv/lcc_crossing_check.sv
// Channel monitor for the level crossing counter: tracks heights, predicts each answer, compares.
`timescale 1ns / 1ps

module lcc_crossing_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_func,
  input  logic [10:0] in_position,
  input  logic [10:0] in_level,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [10:0] out_crossing_count,
  input  logic        end_check,
  output int          fail_count,
  output int          pending_count
);

  import lcc_tb_pkg::*;

  int               row_height    [0:POSITIONS+1];
  int               crossing_tree [1:LEVELS];
  crossing_answer_t expected_answers [$];
  bit               end_seen;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    end_seen      = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic add_to_levels(input int idx, input int delta);
    while (idx >= 1 && idx <= LEVELS) begin
      crossing_tree[idx] += delta;
      idx += idx & -idx;
    end
  endtask

  function automatic int count_at_level(input int idx);
    int sum;
    sum = 0;
    while (idx >= 1) begin
      sum += crossing_tree[idx];
      idx -= idx & -idx;
    end
    return sum;
  endfunction

  // A rising step from lo to hi crosses the levels lo+1 .. hi.
  task automatic apply_step(input int lo, input int hi, input int delta);
    if (lo < hi) begin
      add_to_levels(lo + 1, delta);
      add_to_levels(hi + 1, -delta);
    end
  endtask

  task automatic write_height(input int pos, input int lvl);
    if (pos >= 1 && pos <= POSITIONS) begin
      if (lvl > LEVELS) begin
        lvl = LEVELS;
      end
      apply_step(row_height[pos-1], row_height[pos], -1);
      apply_step(row_height[pos], row_height[pos+1], -1);
      row_height[pos] = lvl;
      apply_step(row_height[pos-1], row_height[pos], 1);
      apply_step(row_height[pos], row_height[pos+1], 1);
    end
  endtask

  always @(posedge clk) begin
    crossing_answer_t answer;
    int               lvl;
    if (!rst_n) begin
      foreach (row_height[i]) row_height[i] = 0;
      foreach (crossing_tree[i]) crossing_tree[i] = 0;
      expected_answers.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          report_mismatch($sformatf("unexpected answer %0d", out_crossing_count));
        end else begin
          answer = expected_answers.pop_front();
          if (out_crossing_count !== answer.count) begin
            report_mismatch($sformatf("level %0d answered %0d, expected %0d",
                                      answer.level, out_crossing_count, answer.count));
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_func == FUNC_QUERY) begin
          lvl          = int'(in_level);
          answer.level = in_level;
          answer.count = (lvl >= 1 && lvl <= LEVELS) ? 11'(count_at_level(lvl)) : 11'd0;
          expected_answers.push_back(answer);
        end else begin
          write_height(int'(in_position), int'(in_level));
        end
      end
      if (end_check && !end_seen) begin
        end_seen = 1'b1;
        while (expected_answers.size() != 0) begin
          answer = expected_answers.pop_front();
          report_mismatch($sformatf("no answer for query at level %0d", answer.level));
        end
      end
    end
    pending_count = expected_answers.size();
  end

endmodule

>>> tb/sv/tb_level_crossing_counter.sv
// Testbench top for the level crossing counter: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_level_crossing_counter;
  import lcc_tb_pkg::*;

  // Number of random items after the directed opening.
  localparam int RANDOM_ITEMS = 1850;
  // The settle time after the last answer covers the longest set walk
  // with room to spare.
  localparam int SETTLE_CYCLES = 250;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_func = FUNC_QUERY;
  logic [10:0] in_position = 11'd0;
  logic [10:0] in_level = 11'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [10:0] out_crossing_count;
  logic        end_check = 1'b0;
  int          fail_count;
  int          pending_count;

  // Percentages of cycles in which the sender holds back and the receiver stalls.
  int send_idle_pct = 24;
  int recv_stall_pct = 54;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  level_crossing_counter #(
    .POSITIONS(POSITIONS),
    .LEVELS   (LEVELS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_position       (in_position),
    .in_level          (in_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_crossing_count(out_crossing_count)
  );

  lcc_crossing_check u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_position       (in_position),
    .in_level          (in_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_crossing_count(out_crossing_count),
    .end_check         (end_check),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  // The receiver decides afresh on every falling edge whether to stall, so
  // stalls can land on any cycle of the block's work, including the one in which
  // an answer first appears.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Presents one item from a falling edge and holds it until the block takes it.
  // A gap of idle cycles may come first; valid only drops inside such a gap, so
  // back-to-back items keep valid high with a new payload.
  task automatic send_item(input logic func, input int pos, input int lvl);
    bit taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= func;
    in_position <= 11'(pos);
    in_level    <= 11'(lvl);
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end
  endtask

  // Most set items land in two narrow windows, at the low end and at the top end
  // of the row, so that neighboring heights interact and steps are removed and
  // re-added often. A share of items is out of range on purpose.
  function automatic int pick_position();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return $urandom_range(1, 24);
    if (roll < 55) return $urandom_range(POSITIONS - 24, POSITIONS);
    if (roll < 85) return $urandom_range(1, POSITIONS);
    if (roll < 90) return 0;
    return $urandom_range(POSITIONS + 1, 2047);
  endfunction

  // Levels lean on the extremes: zero, the top level and values past it, which a
  // set saturates and a query answers with zero.
  function automatic int pick_level();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 0;
    if (roll < 20) return LEVELS;
    if (roll < 30) return $urandom_range(LEVELS + 1, 2047);
    if (roll < 45) return $urandom_range(1, 16);
    return $urandom_range(1, LEVELS);
  endfunction

  initial begin
    // Reset first; the block then clears its stores and keeps in_stall
    // high until done, which the handshake in send_item simply waits out.
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening. An empty row answers zero everywhere, including level
    // zero and levels past the top.
    send_item(FUNC_QUERY, 0, 0);
    send_item(FUNC_QUERY, 0, LEVELS);
    send_item(FUNC_QUERY, 0, LEVELS + 1);
    send_item(FUNC_QUERY, 2047, 2047);
    // A step up to the top level: its range ends at the top, so the subtraction
    // past the last tree entry is dropped.
    send_item(FUNC_SET, 1, LEVELS);
    send_item(FUNC_QUERY, 0, LEVELS);
    send_item(FUNC_QUERY, 0, 1);
    // A height past the top saturates to the top level at the last position.
    send_item(FUNC_SET, POSITIONS, 2047);
    send_item(FUNC_QUERY, 0, LEVELS);
    // Sets at positions outside the row change nothing.
    send_item(FUNC_SET, 0, 5);
    send_item(FUNC_SET, POSITIONS + 1, 7);
    send_item(FUNC_SET, 2047, 1023);
    send_item(FUNC_QUERY, 0, 5);
    // Neighbor interaction: a low step right of a high one, then a zero write.
    send_item(FUNC_SET, 2, 1);
    send_item(FUNC_SET, 512, 0);
    send_item(FUNC_SET, 3, 1023);
    send_item(FUNC_QUERY, 0, 1);
    send_item(FUNC_QUERY, 0, 2);
    send_item(FUNC_QUERY, 0, 512);
    send_item(FUNC_SET, 1, 0);
    send_item(FUNC_QUERY, 0, 1);
    send_item(FUNC_QUERY, 1365, LEVELS);

    // Random part in three idling phases: the sender idles less than the receiver
    // stalls, then the other way round, then neither idles at all.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct  = 54;
        recv_stall_pct = 24;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if ($urandom_range(0, 99) < 45) begin
        // The position field is don't-care for a query; random bits exercise it.
        send_item(FUNC_QUERY, $urandom_range(0, 2047), pick_level());
      end else begin
        send_item(FUNC_SET, pick_position(), pick_level());
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every expected answer, then give the block time to show
    // any stray answer before the leftover check and the verdict.
    wait (pending_count == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    end_check <= 1'b1;
    @(negedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS level_crossing_counter");
    end else begin
      $display("FAIL level_crossing_counter");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run, every set taking its
  // longest walk and every answer waiting out the longest stalls.
  initial begin
    #15_000_000;
    $display("FAIL level_crossing_counter");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/lcc_pkg.sv
rtl/core/lcc_ram.sv
rtl/core/level_crossing_counter.sv
tb/sv/lcc_tb_pkg.sv
tb/sv/lcc_crossing_check.sv
tb/sv/tb_level_crossing_counter.sv
